FILE: rtl/aarm_pkg.sv
// Shared types, constants and elaboration-time tables of the axis-angle rotation unit.
package aarm_pkg;

   localparam int COORD_WIDTH         = 32;
   localparam int CORDIC_ITER_DEFAULT = 24;
   localparam int ATAN_SLOTS          = 60;

   // pipeline depths of the fixed sections
   localparam int ANGLE_LAT  = 4;
   localparam int AXIS_LAT   = 3;
   localparam int MATRIX_LAT = 3;
   localparam int SHIFT_LAT  = 3;

   localparam logic signed [63:0] CORDIC_X0 = 64'sd652032874 <<< 30;
   localparam logic signed [63:0] Q60_ONE   = 64'sd1 <<< 60;
   localparam logic signed [63:0] HALF_Q30  = 64'sd1 <<< 29;

   typedef logic [63:0] atan_tab_type [ATAN_SLOTS];

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] center_x;
      logic signed [COORD_WIDTH-1:0] center_y;
      logic signed [COORD_WIDTH-1:0] center_z;
      logic signed [31:0]            axis_x;
      logic signed [31:0]            axis_y;
      logic signed [31:0]            axis_z;
      logic signed [31:0]            angle_deg;
   } req_type;

   typedef struct packed {
      logic signed [31:0]            m11;
      logic signed [31:0]            m12;
      logic signed [31:0]            m13;
      logic signed [31:0]            m21;
      logic signed [31:0]            m22;
      logic signed [31:0]            m23;
      logic signed [31:0]            m31;
      logic signed [31:0]            m32;
      logic signed [31:0]            m33;
      logic signed [COORD_WIDTH-1:0] shift_x;
      logic signed [COORD_WIDTH-1:0] shift_y;
      logic signed [COORD_WIDTH-1:0] shift_z;
   } rsp_type;

   // clamped axis, rounded Q30 squares for the diagonal, rounded Q30 cross terms (xy, xz, yz)
   typedef struct packed {
      logic [2:0][31:0] u;
      logic [2:0][32:0] wd;
      logic [2:0][31:0] wo;
   } axis_terms_type;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic               flip;
   } cordic_type;

   typedef struct packed {
      logic [8:0][31:0] m;
   } mat_type;

   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0] c;
   } center_type;

   // restoring division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r    = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // truncated alternating series of atan(1/n) in Q60
   function automatic logic [63:0] atan_inv(input logic [63:0] n);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] t;
      logic [63:0] k;
      p   = udiv64(64'd1 << 60, n);
      sum = '0;
      k   = '0;
      while (p != 0) begin
         t = udiv64(p, (k << 1) + 64'd1);
         if (k[0]) begin
            sum = sum - t;
         end else begin
            sum = sum + t;
         end
         p = udiv64(udiv64(p, n), n);
         k = k + 64'd1;
      end
      return sum;
   endfunction

   function automatic atan_tab_type atan_table();
      atan_tab_type tab;
      tab[0] = atan_inv(64'd2) + atan_inv(64'd3);
      for (int i = 1; i < ATAN_SLOTS; i++) begin
         tab[i] = atan_inv(64'd1 << i);
      end
      return tab;
   endfunction

   localparam atan_tab_type ATAN_TAB = atan_table();

   // Q16.16 degrees to Q60 radians
   localparam logic [63:0] KQ_WORD = ((64'd4 * ATAN_TAB[0]) / 64'd180 + 64'd32768) >> 16;

endpackage

FILE: rtl/axis_angle_rotation_matrix_unit.sv
// Top level of the axis-angle rotation unit: rotation matrix and centre translation.
//
//   channel   ports                      direction  handshake
//   request   start, busy, req_word      in         taken when start high and busy low
//   result    rsp_valid, rsp_word        out        one-cycle strobe, no back-pressure
//
// A new word is taken every cycle while busy is low; each result passes through
// the angle stages, the unrolled CORDIC (one iteration per stage) and then the
// matrix and translation stages.
// Reset is synchronous and clears every valid bit; busy follows reset, so no word
// is taken while it is held. The receiver cannot stall, so the pipeline never holds.
module axis_angle_rotation_matrix_unit import aarm_pkg::*; #(
   parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   // centre waits for angle, CORDIC and matrix sections
   localparam int CEN_DELAY  = ANGLE_LAT + CORDIC_ITERATIONS + MATRIX_LAT;
   // axis terms wait out the CORDIC and the extra angle stage
   localparam int AXIS_DELAY = CORDIC_ITERATIONS + ANGLE_LAT - AXIS_LAT;

   logic           accept;
   logic           ang_valid;
   logic signed [63:0] ang_z;
   logic           ang_flip;
   logic           cor_valid;
   cordic_type     cor_result;
   axis_terms_type axis_terms;
   logic           mat_valid;
   mat_type        mat_word;
   mat_type        out_mat;
   logic           out_valid;
   logic [2:0][COORD_WIDTH-1:0] out_shift;

   axis_terms_type axis_dly_ff [AXIS_DELAY];
   center_type     cen_dly_ff  [CEN_DELAY];
   center_type     cen_now;

   // hold off requests while reset is applied
   assign busy   = reset;
   assign accept = start && !busy;

   assign cen_now.c = {req_word.center_z, req_word.center_y, req_word.center_x};

   aarm_angle_reduce u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle_in  (req_word.angle_deg),
      .out_valid (ang_valid),
      .z_out     (ang_z),
      .flip_out  (ang_flip)
   );

   aarm_axis_terms u_axis (
      .clock     (clock),
      .axis_x    (req_word.axis_x),
      .axis_y    (req_word.axis_y),
      .axis_z    (req_word.axis_z),
      .terms_out (axis_terms)
   );

   aarm_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (ang_valid),
      .z_in       (ang_z),
      .flip_in    (ang_flip),
      .out_valid  (cor_valid),
      .result_out (cor_result)
   );

   // advance side data in step with the valid bits; payload needs no reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < AXIS_DELAY; k++) begin
         axis_dly_ff[k] <= (k == 0) ? axis_terms : axis_dly_ff[(k == 0) ? 0 : k - 1];
      end
      for (int k = 0; k < CEN_DELAY; k++) begin
         cen_dly_ff[k] <= (k == 0) ? cen_now : cen_dly_ff[(k == 0) ? 0 : k - 1];
      end
   end

   aarm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cor_valid),
      .trig_in   (cor_result),
      .terms_in  (axis_dly_ff[AXIS_DELAY-1]),
      .out_valid (mat_valid),
      .mat_out   (mat_word)
   );

   aarm_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .mat_in    (mat_word),
      .cen_in    (cen_dly_ff[CEN_DELAY-1]),
      .out_valid (out_valid),
      .mat_out   (out_mat),
      .shift_out (out_shift)
   );

   // drive the result word straight from the last stage's registers
   assign rsp_valid        = out_valid;
   assign rsp_word.m11     = out_mat.m[0];
   assign rsp_word.m12     = out_mat.m[1];
   assign rsp_word.m13     = out_mat.m[2];
   assign rsp_word.m21     = out_mat.m[3];
   assign rsp_word.m22     = out_mat.m[4];
   assign rsp_word.m23     = out_mat.m[5];
   assign rsp_word.m31     = out_mat.m[6];
   assign rsp_word.m32     = out_mat.m[7];
   assign rsp_word.m33     = out_mat.m[8];
   assign rsp_word.shift_x = out_shift[0];
   assign rsp_word.shift_y = out_shift[1];
   assign rsp_word.shift_z = out_shift[2];

endmodule

FILE: rtl/aarm_angle_reduce.sv
// Angle reduction modulo 360 degrees, quarter-turn fold and scaling to Q60 radians.
module aarm_angle_reduce import aarm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] angle_in,
   output logic               out_valid,
   output logic signed [63:0] z_out,
   output logic               flip_out
);

   localparam logic signed [25:0] TURN    = 26'sd23592960;
   localparam logic signed [25:0] HALF    = 26'sd11796480;
   localparam logic signed [25:0] QUARTER = 26'sd5898240;
   localparam logic signed [39:0] KQ_S    = signed'({1'b0, KQ_WORD[38:0]});

   // stage 1: upper bits offset by 4096, quotient estimate by 45 (never above the true one)
   logic [12:0] v_in;
   logic [23:0] prod_q;
   logic        vld1_ff;
   logic [12:0] v1_ff;
   logic [7:0]  q1_ff;
   logic [18:0] lo1_ff;

   assign v_in   = {~angle_in[31], angle_in[30:19]};
   assign prod_q = v_in * 11'd1456;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
      v1_ff  <= v_in;
      q1_ff  <= prod_q[23:16];
      lo1_ff <= angle_in[18:0];
   end

   // stage 2: remainder, correct once, undo the offset
   logic [13:0] qm;
   logic [13:0] rem;
   logic [5:0]  rc;
   logic [5:0]  rm;
   logic        vld2_ff;
   logic [24:0] ang2_ff;

   always_comb begin
      qm  = q1_ff * 6'd45;
      rem = {1'b0, v1_ff} - qm;
      rc  = (rem >= 14'd45) ? 6'(rem - 14'd45) : rem[5:0];
      rm  = (rc == 6'd0) ? 6'd44 : rc - 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
      ang2_ff <= {rm, lo1_ff};
   end

   // stage 3: into (-180,180], then fold into [-90,90]
   logic signed [25:0] a_w;
   logic signed [25:0] a_f;
   logic               flip_w;
   logic               vld3_ff;
   logic signed [23:0] ang3_ff;
   logic               flip3_ff;

   always_comb begin
      a_w = signed'({1'b0, ang2_ff});
      if (a_w > HALF) begin
         a_w = a_w - TURN;
      end
      flip_w = 1'b0;
      a_f    = a_w;
      priority if (a_w > QUARTER) begin
         a_f    = HALF - a_w;
         flip_w = 1'b1;
      end else if (a_w < -QUARTER) begin
         a_f    = -HALF - a_w;
         flip_w = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= vld2_ff;
      end
      ang3_ff  <= a_f[23:0];
      flip3_ff <= flip_w;
   end

   // stage 4: Q60 radians
   logic signed [63:0] z_w;
   logic               vld4_ff;
   logic signed [63:0] z4_ff;
   logic               flip4_ff;

   assign z_w = ang3_ff * KQ_S;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else begin
         vld4_ff <= vld3_ff;
      end
      z4_ff    <= z_w;
      flip4_ff <= flip3_ff;
   end

   assign out_valid = vld4_ff;
   assign z_out     = z4_ff;
   assign flip_out  = flip4_ff;

endmodule

FILE: rtl/aarm_axis_terms.sv
// Axis clamp and the rounded products of axis components.
module aarm_axis_terms import aarm_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] axis_x,
   input  logic signed [31:0] axis_y,
   input  logic signed [31:0] axis_z,
   output axis_terms_type     terms_out
);

   localparam logic signed [31:0] U_MAX = 32'sd1073741824;

   logic [2:0][31:0]   u_raw;
   logic [2:0][31:0]   u_in;
   logic [2:0][31:0]   u1_ff;
   logic [2:0][31:0]   u2_ff;
   logic signed [63:0] sq_ff [3];
   logic signed [63:0] cr_ff [3];
   axis_terms_type     terms_ff;
   axis_terms_type     terms_in;
   logic signed [63:0] dsum;
   logic signed [63:0] osum;

   assign u_raw = {axis_z, axis_y, axis_x};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         priority if ($signed(u_raw[k]) > U_MAX) begin
            u_in[k] = U_MAX;
         end else if ($signed(u_raw[k]) < -U_MAX) begin
            u_in[k] = -U_MAX;
         end else begin
            u_in[k] = u_raw[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      u1_ff <= u_in;
      u2_ff <= u1_ff;
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= $signed(u1_ff[k]) * $signed(u1_ff[k]);
      end
      cr_ff[0] <= $signed(u1_ff[0]) * $signed(u1_ff[1]);
      cr_ff[1] <= $signed(u1_ff[0]) * $signed(u1_ff[2]);
      cr_ff[2] <= $signed(u1_ff[1]) * $signed(u1_ff[2]);
      terms_ff <= terms_in;
   end

   // diagonal k takes the squares of the other two components
   always_comb begin
      terms_in.u = u2_ff;
      for (int k = 0; k < 3; k++) begin
         dsum = sq_ff[(k + 1) % 3] + sq_ff[(k + 2) % 3] + HALF_Q30;
         terms_in.wd[k] = dsum[62:30];
         osum = cr_ff[k] + HALF_Q30;
         terms_in.wo[k] = osum[61:30];
      end
   end

   assign terms_out = terms_ff;

endmodule

FILE: rtl/aarm_cordic.sv
// Unrolled rotation-mode CORDIC, one iteration per register stage.
module aarm_cordic import aarm_pkg::*; #(
   parameter int ITERATIONS = CORDIC_ITER_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [63:0] z_in,
   input  logic               flip_in,
   output logic               out_valid,
   output cordic_type         result_out
);

   logic signed [63:0] x_ff [ITERATIONS];
   logic signed [63:0] y_ff [ITERATIONS];
   logic signed [63:0] z_ff [ITERATIONS];
   logic signed [63:0] x_in [ITERATIONS];
   logic signed [63:0] y_in [ITERATIONS];
   logic signed [63:0] z_in_s [ITERATIONS];
   logic               flip_ff [ITERATIONS];
   logic               vld_ff [ITERATIONS];

   always_comb begin
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      logic signed [63:0] zs;
      logic signed [63:0] tab;
      for (int s = 0; s < ITERATIONS; s++) begin
         if (s == 0) begin
            xs = CORDIC_X0;
            ys = '0;
            zs = z_in;
         end else begin
            xs = x_ff[s-1];
            ys = y_ff[s-1];
            zs = z_ff[s-1];
         end
         tab = signed'(ATAN_TAB[s]);
         if (!zs[63]) begin
            x_in[s]   = xs - (ys >>> s);
            y_in[s]   = ys + (xs >>> s);
            z_in_s[s] = zs - tab;
         end else begin
            x_in[s]   = xs + (ys >>> s);
            y_in[s]   = ys - (xs >>> s);
            z_in_s[s] = zs + tab;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < ITERATIONS; s++) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s - 1];
         end
         x_ff[s]    <= x_in[s];
         y_ff[s]    <= y_in[s];
         z_ff[s]    <= z_in_s[s];
         flip_ff[s] <= (s == 0) ? flip_in : flip_ff[(s == 0) ? 0 : s - 1];
      end
   end

   assign out_valid       = vld_ff[ITERATIONS-1];
   assign result_out.x    = x_ff[ITERATIONS-1];
   assign result_out.y    = y_ff[ITERATIONS-1];
   assign result_out.flip = flip_ff[ITERATIONS-1];

endmodule

FILE: rtl/aarm_matrix.sv
// Rodrigues rotation entries from sine, cosine and the axis terms.
module aarm_matrix import aarm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  cordic_type     trig_in,
   input  axis_terms_type terms_in,
   output logic           out_valid,
   output mat_type        mat_out
);

   localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

   // stage 1: round and clamp sine and cosine, form 1 - cos
   logic signed [63:0] rx;
   logic signed [63:0] ry;
   logic signed [63:0] co_w;
   logic signed [63:0] si_w;
   logic signed [63:0] f2_w;
   logic               vld1_ff;
   logic signed [32:0] f2_ff;
   logic signed [31:0] si_ff;
   axis_terms_type     terms1_ff;

   always_comb begin
      rx = (trig_in.x + HALF_Q30) >>> 30;
      ry = (trig_in.y + HALF_Q30) >>> 30;
      priority if (rx > ONE_Q30) begin
         co_w = ONE_Q30;
      end else if (rx < -ONE_Q30) begin
         co_w = -ONE_Q30;
      end else begin
         co_w = rx;
      end
      priority if (ry > ONE_Q30) begin
         si_w = ONE_Q30;
      end else if (ry < -ONE_Q30) begin
         si_w = -ONE_Q30;
      end else begin
         si_w = ry;
      end
      if (trig_in.flip) begin
         co_w = -co_w;
      end
      f2_w = ONE_Q30 - co_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
      f2_ff     <= f2_w[32:0];
      si_ff     <= si_w[31:0];
      terms1_ff <= terms_in;
   end

   // stage 2: products
   logic               vld2_ff;
   logic signed [63:0] pd_ff [3];
   logic signed [63:0] po_ff [3];
   logic signed [63:0] ps_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
      for (int k = 0; k < 3; k++) begin
         pd_ff[k] <= f2_ff * $signed(terms1_ff.wd[k]);
         po_ff[k] <= f2_ff * $signed(terms1_ff.wo[k]);
         ps_ff[k] <= si_ff * $signed(terms1_ff.u[k]);
      end
   end

   // stage 3: sums, round to Q30, saturate to 32 bits
   logic signed [63:0] v [9];
   logic signed [63:0] r;
   mat_type            mat_in;
   logic               vld3_ff;
   mat_type            mat_ff;

   always_comb begin
      v[0] = Q60_ONE - pd_ff[0];
      v[1] = po_ff[0] - ps_ff[2];
      v[2] = po_ff[1] + ps_ff[1];
      v[3] = po_ff[0] + ps_ff[2];
      v[4] = Q60_ONE - pd_ff[1];
      v[5] = po_ff[2] - ps_ff[0];
      v[6] = po_ff[1] - ps_ff[1];
      v[7] = po_ff[2] + ps_ff[0];
      v[8] = Q60_ONE - pd_ff[2];
      for (int k = 0; k < 9; k++) begin
         r = (v[k] + HALF_Q30) >>> 30;
         if (r[63:31] == {33{r[63]}}) begin
            mat_in.m[k] = r[31:0];
         end else begin
            mat_in.m[k] = r[63] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= vld2_ff;
      end
      mat_ff <= mat_in;
   end

   assign out_valid = vld3_ff;
   assign mat_out   = mat_ff;

endmodule

FILE: rtl/aarm_shift.sv
// Translation c - R*c, rounded to Q16.16 and saturated; carries the matrix alongside.
module aarm_shift import aarm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  mat_type    mat_in,
   input  center_type cen_in,
   output logic       out_valid,
   output mat_type    mat_out,
   output logic [2:0][COORD_WIDTH-1:0] shift_out
);

   localparam int PROD_W = 32 + COORD_WIDTH;
   localparam int ACC_W  = COORD_WIDTH + 35;
   localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(64'sd1 <<< 29);

   // stage 1: the nine products
   logic                     vld1_ff;
   logic signed [PROD_W-1:0] p_ff [9];
   center_type               cen1_ff;
   mat_type                  mat1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
      end
      for (int k = 0; k < 9; k++) begin
         p_ff[k] <= $signed(mat_in.m[k]) * $signed(cen_in.c[k % 3]);
      end
      cen1_ff <= cen_in;
      mat1_ff <= mat_in;
   end

   // stage 2: row sums
   logic                    vld2_ff;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [ACC_W-1:0] acc_in [3];
   mat_type                 mat2_ff;

   always_comb begin
      for (int rr = 0; rr < 3; rr++) begin
         acc_in[rr] = (ACC_W'($signed(cen1_ff.c[rr])) <<< 30)
                    - ACC_W'(p_ff[3*rr]) - ACC_W'(p_ff[3*rr+1]) - ACC_W'(p_ff[3*rr+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
      for (int rr = 0; rr < 3; rr++) begin
         acc_ff[rr] <= acc_in[rr];
      end
      mat2_ff <= mat1_ff;
   end

   // stage 3: round to Q16.16 and saturate
   logic signed [ACC_W-1:0]     s;
   logic [2:0][COORD_WIDTH-1:0] sat_in;
   logic                        vld3_ff;
   logic [2:0][COORD_WIDTH-1:0] sat_ff;
   mat_type                     mat3_ff;

   always_comb begin
      for (int rr = 0; rr < 3; rr++) begin
         s = (acc_ff[rr] + HALF_ACC) >>> 30;
         if (s[ACC_W-1:COORD_WIDTH-1] == {(ACC_W-COORD_WIDTH+1){s[ACC_W-1]}}) begin
            sat_in[rr] = s[COORD_WIDTH-1:0];
         end else begin
            sat_in[rr] = s[ACC_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                    : {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= vld2_ff;
      end
      sat_ff  <= sat_in;
      mat3_ff <= mat2_ff;
   end

   assign out_valid = vld3_ff;
   assign mat_out   = mat3_ff;
   assign shift_out = sat_ff;

endmodule

FILE: rtl/aarm_checker.sv
// Port-level timing checks of the rotation unit and their binding.
module aarm_checker import aarm_pkg::*; #(
   parameter int ITERATIONS = CORDIC_ITER_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_word
);

   localparam int LAT = ANGLE_LAT + ITERATIONS + MATRIX_LAT + SHIFT_LAT;
   localparam int CW  = $clog2(LAT + 1);

   logic [CW-1:0] since_ff;

   // count clean cycles since reset, hold at the latency
   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff <= '0;
      end else if (since_ff != CW'(LAT)) begin
         since_ff <= since_ff + 1'b1;
      end
   end

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result word without a request at the pipeline latency");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (since_ff == CW'(LAT)) && $past(start && !busy, LAT) |-> rsp_valid)
      else $error("request word produced no result");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_word))
      else $error("result word carries unknown bits");

endmodule

bind axis_angle_rotation_matrix_unit aarm_checker #(
   .ITERATIONS (CORDIC_ITERATIONS)
) u_aarm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);

FILE: verif/axis_angle_rotation_matrix_unit_tb.sv
// Self-checking testbench of the axis-angle rotation unit: directed table, then random words.
`timescale 1ns / 100ps

module axis_angle_rotation_matrix_unit_tb;
   import aarm_pkg::*;

   localparam int LATENCY      = ANGLE_LAT + CORDIC_ITER_DEFAULT + MATRIX_LAT + SHIFT_LAT;
   localparam int N_RANDOM     = 1950;
   localparam int WATCHDOG_MAX = 20000;
   localparam int N_DIRECTED   = 18;
   localparam logic signed [31:0] Q30 = 32'sd1073741824;
   localparam logic signed [31:0] DEG = 32'sd65536;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_valid;
   rsp_type rsp_word;

   axis_angle_rotation_matrix_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   always #4 clock = ~clock;

   // Arctangent table and degree scale, built independently of the package.
   logic [63:0] arctan_q60 [60];
   longint      deg_to_rad_q60;

   rsp_type transform_queue[$];
   int      mismatch_count = 0;
   int      watchdog = 0;
   bit      timed_out = 0;

   function automatic logic [63:0] series_arctan(input logic [63:0] n);
      logic [63:0] p, sum, k;
      p = (64'd1 << 60) / n;
      sum = 0;
      k = 0;
      while (p != 0) begin
         if (k[0]) sum = sum - p / (2 * k + 1);
         else sum = sum + p / (2 * k + 1);
         p = p / n / n;
         k++;
      end
      return sum;
   endfunction

   function automatic longint round_q30(input longint v);
      return (v + (longint'(1) <<< 29)) >>> 30;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Rodrigues matrix and centre translation for one request word.
   function automatic rsp_type rotation_transform(input req_type w);
      longint cen[3], u[3], r[3][3];
      longint ang, x, y, z, dx, dy, co, si, f2, v, sk, a, b;
      logic signed [127:0] acc, rnd;
      bit flip;
      rsp_type res;
      logic [31:0] mw[9];
      logic [31:0] sw[3];
      cen[0] = w.center_x; cen[1] = w.center_y; cen[2] = w.center_z;
      u[0] = clip(w.axis_x, -Q30, Q30);
      u[1] = clip(w.axis_y, -Q30, Q30);
      u[2] = clip(w.axis_z, -Q30, Q30);
      flip = 0;
      ang = longint'(w.angle_deg) % (longint'(360) <<< 16);
      if (ang < 0) ang += longint'(360) <<< 16;
      if (ang > (longint'(180) <<< 16)) ang -= longint'(360) <<< 16;
      if (ang > (longint'(90) <<< 16)) begin
         ang = (longint'(180) <<< 16) - ang; flip = 1;
      end else if (ang < -(longint'(90) <<< 16)) begin
         ang = -(longint'(180) <<< 16) - ang; flip = 1;
      end
      x = longint'(652032874) <<< 30;
      y = 0;
      z = ang * deg_to_rad_q60;
      for (int i = 0; i < CORDIC_ITER_DEFAULT; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(arctan_q60[i]);
         end else begin
            x += dx; y -= dy; z += longint'(arctan_q60[i]);
         end
      end
      co = clip(round_q30(x), -Q30, Q30);
      si = clip(round_q30(y), -Q30, Q30);
      if (flip) co = -co;
      f2 = Q30 - co;
      for (int rr = 0; rr < 3; rr++) begin
         for (int cc = 0; cc < 3; cc++) begin
            if (rr == cc) begin
               a = u[(rr + 1) % 3];
               b = u[(rr + 2) % 3];
               v = (longint'(1) <<< 60) - f2 * round_q30(a * a + b * b);
            end else begin
               sk = u[3 - rr - cc];
               if ((cc - rr + 3) % 3 != 2) sk = -sk;
               v = si * sk + f2 * round_q30(u[rr] * u[cc]);
            end
            r[rr][cc] = clip(round_q30(v), -64'sd2147483648, 64'sd2147483647);
            mw[rr * 3 + cc] = r[rr][cc][31:0];
         end
      end
      for (int rr = 0; rr < 3; rr++) begin
         acc = 128'(cen[rr]) <<< 30;
         for (int cc = 0; cc < 3; cc++)
            acc = acc - 128'(cen[cc]) * 128'(r[rr][cc]);
         rnd = (acc + (128'sd1 <<< 29)) >>> 30;
         if (rnd > 128'sd2147483647) rnd = 128'sd2147483647;
         if (rnd < -128'sd2147483648) rnd = -128'sd2147483648;
         sw[rr] = rnd[31:0];
      end
      res = {mw[0], mw[1], mw[2], mw[3], mw[4], mw[5], mw[6], mw[7], mw[8],
             sw[0], sw[1], sw[2]};
      return res;
   endfunction

   // Directed rows: a hand-typed result only where it is obvious.
   typedef struct {
      req_type w;
      bit      known;
      rsp_type r;
   } row_type;
   row_type directed_rows [N_DIRECTED];

   function automatic req_type make_word(input logic [31:0] cx, cy, cz, ax, ay, az, ang);
      req_type w;
      w = {cx, cy, cz, ax, ay, az, ang};
      return w;
   endfunction

   initial begin
      rsp_type ident;
      ident = '0;
      ident.m11 = Q30; ident.m22 = Q30; ident.m33 = Q30;
      // zero angle about z at the origin; the CORDIC leaves a tiny residual sine
      directed_rows[0] = '{make_word(0, 0, 0, 0, 0, Q30, 0), 0, '0};
      // zero axis: the formula leaves the identity, whatever the angle
      directed_rows[1] = '{make_word(0, 0, 0, 0, 0, 0, 90 * DEG), 1, ident};
      // full turn reduces to zero
      directed_rows[2] = '{make_word(0, 0, 0, Q30, 0, 0, 360 * DEG), 0, '0};
      directed_rows[3] = '{make_word(DEG, 2 * DEG, 3 * DEG, Q30, 0, 0, 90 * DEG), 0, '0};
      directed_rows[4] = '{make_word(DEG, 0, 0, 0, Q30, 0, 90 * DEG), 0, '0};
      directed_rows[5] = '{make_word(DEG, DEG, 0, 0, 0, Q30, 180 * DEG), 0, '0};
      directed_rows[6] = '{make_word(0, 0, DEG, 0, 0, -Q30, -90 * DEG), 0, '0};
      directed_rows[7] = '{make_word(0, 0, 0, Q30, 0, 0, -180 * DEG), 0, '0};
      directed_rows[8] = '{make_word(0, 0, 0, 0, Q30, 0, 135 * DEG), 0, '0};
      directed_rows[9] = '{make_word(0, 0, 0, 0, Q30, 0, -135 * DEG), 0, '0};
      // axis components out of range saturate; non-unit axis used as given
      directed_rows[10] = '{make_word(DEG, DEG, DEG, 32'h7fffffff, 32'h80000000,
                                      32'h7fffffff, 45 * DEG), 0, '0};
      directed_rows[11] = '{make_word(0, 0, 0, Q30, Q30, Q30, 60 * DEG), 0, '0};
      // extreme centres drive the shift into saturation
      directed_rows[12] = '{make_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      0, 0, Q30, 180 * DEG), 0, '0};
      directed_rows[13] = '{make_word(32'h80000000, 32'h80000000, 32'h80000000,
                                      Q30, 0, 0, 180 * DEG), 0, '0};
      directed_rows[14] = '{make_word(32'h80000000, 32'h7fffffff, 0,
                                      -Q30, -Q30, -Q30, 32'h7fffffff), 0, '0};
      directed_rows[15] = '{make_word(0, 0, 0, 0, 0, Q30, 32'h80000000), 0, '0};
      directed_rows[16] = '{make_word(DEG, DEG, DEG, 0, 0, Q30, 90 * DEG), 0, '0};
      directed_rows[17] = '{make_word(32'hffffffff, 1, 32'h55555555,
                                      32'h2d413ccd, 32'h2d413ccd, 0, 32'h00008000), 0, '0};
   end

   // Send one word: drop start for the drawn gap, then hold it until the unit takes the word.
   task automatic send_word(input req_type w, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic post(input req_type w, input bit known, input rsp_type r);
      if (known) transform_queue.push_back(r);
      else transform_queue.push_back(rotation_transform(w));
   endtask

   // Random word: mostly unit-like axes and moderate values, with raw noise mixed in.
   function automatic req_type random_word();
      req_type w;
      int pick;
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         w.axis_x = $urandom_range(0, 1) ? Q30 : -Q30;
         w.axis_y = 0; w.axis_z = 0;
         if (pick == 1) begin w.axis_y = w.axis_x; w.axis_x = 0; end
         if (pick == 2) begin w.axis_z = w.axis_x; w.axis_x = 0; end
      end else if (pick < 8) begin
         w.axis_x = $signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000;
         w.axis_y = $signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000;
         w.axis_z = $signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000;
      end
      if (pick < 6) w.angle_deg = $signed($urandom_range(0, 1440 * 65536)) - 720 * DEG;
      if (pick == 3 || pick == 5) begin
         w.center_x = $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
         w.center_y = $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
         w.center_z = $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
      end
      return w;
   endfunction

   // Stimulus
   initial begin
      req_type w;
      arctan_q60[0] = series_arctan(2) + series_arctan(3);
      for (int i = 1; i < 60; i++) arctan_q60[i] = series_arctan(64'd1 << i);
      deg_to_rad_q60 = longint'(((64'd4 * arctan_q60[0]) / 180 + 64'd32768) >> 16);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int k = 0; k < N_DIRECTED; k++) begin
         send_word(directed_rows[k].w, $urandom_range(0, 1) ? 0 : $urandom_range(0, 12));
         post(directed_rows[k].w, directed_rows[k].known, directed_rows[k].r);
      end
      // hold off until every directed result is back
      start <= 1'b0;
      while (transform_queue.size() != 0) @(posedge clock);
      for (int k = 0; k < N_RANDOM; k++) begin
         w = random_word();
         // bursts with no gaps alternate with gappy stretches
         send_word(w, ((k / 100) % 2) ? 0 : $urandom_range(0, 12));
         post(w, 0, '0);
         if (k == 1000) begin
            start <= 1'b0;
            while (transform_queue.size() != 0) @(posedge clock);
         end
      end
      start <= 1'b0;
      while (transform_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0 && !timed_out) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   // Result checker: compare each strobed word with the oldest expectation.
   always @(posedge clock) begin
      rsp_type expd;
      if (!reset && rsp_valid) begin
         if (transform_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_word);
         end else begin
            expd = transform_queue.pop_front();
            if (rsp_word !== expd) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h actual %h", expd, rsp_word);
            end
         end
      end
   end

   // Watchdog: count cycles in which no word moves either way.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_MAX) begin
         timed_out = 1;
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

FILE: sim.f
rtl/aarm_pkg.sv
rtl/aarm_angle_reduce.sv
rtl/aarm_axis_terms.sv
rtl/aarm_cordic.sv
rtl/aarm_matrix.sv
rtl/aarm_shift.sv
rtl/axis_angle_rotation_matrix_unit.sv
rtl/aarm_checker.sv
verif/axis_angle_rotation_matrix_unit_tb.sv
